// File: rtl/pso_pdu_pkg.sv
// Shared widths, register indexes and reset values for the particle dimension update.
package pso_pdu_pkg;

  localparam int unsigned ValW    = 32;  // Q16.16 coordinate width
  localparam int unsigned WgtW    = 16;  // Q4.12 weight width
  localparam int unsigned RndW    = 16;  // Q0.16 random width
  localparam int unsigned LimW    = 31;  // velocity limit width
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 31;
  localparam int unsigned InDataW  = 6 * ValW + 2 * RndW;
  localparam int unsigned OutDataW = 2 * ValW;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_MODE    = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_INERTIA = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_COG     = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_SOC     = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_CHI     = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_VLIMIT  = 3'd5;

  // reset values
  localparam logic [WgtW-1:0] RST_INERTIA = 16'd2989;
  localparam logic [WgtW-1:0] RST_COG     = 16'd6121;
  localparam logic [WgtW-1:0] RST_SOC     = 16'd6121;
  localparam logic [WgtW-1:0] RST_CHI     = 16'd2989;

endpackage

// File: rtl/pso_particle_dimension_update.sv
// Seven register stages: stages 1 to 6 and the output register, which drives
// out_tdata and out_tlast.
// Throughput one dimension per cycle; the whole pipe holds while the output
// stage is full and out_tready is low, and in_tready is low exactly then.
// The longest stage is the 17 x 40 bit constriction multiply.
// Synchronous active-low reset clears stage valid bits and restores the
// configuration registers to their defaults; no clearing pass is needed.
module pso_particle_dimension_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pso_pdu_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [pso_pdu_pkg::CfgDataW-1:0]    cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // position, velocity, personal_best, neighborhood_best, lower_bound,
  // upper_bound, rand_cognitive, rand_social (lowest bit up)
  input  logic [pso_pdu_pkg::InDataW-1:0]     in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // new_position, new_velocity (lowest bit up)
  output logic [pso_pdu_pkg::OutDataW-1:0]    out_tdata,
  output logic                                out_tlast
);
  import pso_pdu_pkg::*;

  // configuration
  logic                mode_r;
  logic [WgtW-1:0]     inertia_r, cog_r, soc_r, chi_r;
  logic [LimW-1:0]     vlimit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      inertia_r <= RST_INERTIA;
      cog_r     <= RST_COG;
      soc_r     <= RST_SOC;
      chi_r     <= RST_CHI;
      vlimit_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_MODE:    mode_r    <= cfg_wdata[0];
        REG_INERTIA: inertia_r <= cfg_wdata[WgtW-1:0];
        REG_COG:     cog_r     <= cfg_wdata[WgtW-1:0];
        REG_SOC:     soc_r     <= cfg_wdata[WgtW-1:0];
        REG_CHI:     chi_r     <= cfg_wdata[WgtW-1:0];
        REG_VLIMIT:  vlimit_r  <= cfg_wdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and global advance
  logic [6:0] vld_r;
  logic       adv;

  assign adv        = !vld_r[6] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[5:0], in_tvalid};
    end
  end

  // ---------------- stage 1: differences, coefficients, speed limit
  logic signed [31:0] in_x, in_v, in_p, in_g, in_lo, in_hi;
  logic        [15:0] in_r1, in_r2;
  logic        [31:0] k1_prod, k2_prod;
  logic signed [32:0] half_span;

  assign in_x  = in_tdata[31:0];
  assign in_v  = in_tdata[63:32];
  assign in_p  = in_tdata[95:64];
  assign in_g  = in_tdata[127:96];
  assign in_lo = in_tdata[159:128];
  assign in_hi = in_tdata[191:160];
  assign in_r1 = in_tdata[207:192];
  assign in_r2 = in_tdata[223:208];

  // round half up to Q4.12; the sum cannot carry past bit 31
  assign k1_prod   = 32'(cog_r) * 32'(in_r1) + 32'h0000_8000;
  assign k2_prod   = 32'(soc_r) * 32'(in_r2) + 32'h0000_8000;
  assign half_span = 33'(in_hi) - 33'(in_lo);

  logic signed [31:0] s1_x_r, s1_v_r, s1_lo_r, s1_hi_r, s1_vmax_r;
  logic signed [32:0] s1_d1_r, s1_d2_r;
  logic        [15:0] s1_k1_r, s1_k2_r;
  logic               s1_last_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r    <= in_x;
      s1_v_r    <= in_v;
      s1_lo_r   <= in_lo;
      s1_hi_r   <= in_hi;
      s1_d1_r   <= 33'(in_p) - 33'(in_x);
      s1_d2_r   <= 33'(in_g) - 33'(in_x);
      s1_k1_r   <= k1_prod[31:16];
      s1_k2_r   <= k2_prod[31:16];
      // zero limit falls back to floor of half the bound span
      s1_vmax_r <= (vlimit_r != '0) ? $signed({1'b0, vlimit_r}) : half_span[32:1];
      s1_last_r <= in_tlast;
    end
  end

  // ---------------- stage 2: pull terms and inertia product
  logic signed [49:0] t1_prod, t2_prod;
  logic signed [48:0] wv_prod;

  assign t1_prod = $signed({1'b0, s1_k1_r}) * s1_d1_r + 50'sd2048;
  assign t2_prod = $signed({1'b0, s1_k2_r}) * s1_d2_r + 50'sd2048;
  assign wv_prod = $signed({1'b0, inertia_r}) * s1_v_r + 49'sd2048;

  logic signed [37:0] s2_t1_r, s2_t2_r;
  logic signed [36:0] s2_wv_r;
  logic signed [31:0] s2_x_r, s2_v_r, s2_lo_r, s2_hi_r, s2_vmax_r;
  logic               s2_last_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_t1_r   <= t1_prod[49:12];
      s2_t2_r   <= t2_prod[49:12];
      s2_wv_r   <= wv_prod[48:12];
      s2_x_r    <= s1_x_r;
      s2_v_r    <= s1_v_r;
      s2_lo_r   <= s1_lo_r;
      s2_hi_r   <= s1_hi_r;
      s2_vmax_r <= s1_vmax_r;
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------- stage 3: sum of terms
  logic signed [39:0] s3_acc_r;
  logic signed [31:0] s3_x_r, s3_lo_r, s3_hi_r, s3_vmax_r;
  logic               s3_last_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (mode_r) begin
        s3_acc_r <= 40'(s2_v_r) + 40'(s2_t1_r) + 40'(s2_t2_r);
      end else begin
        s3_acc_r <= 40'(s2_wv_r) + 40'(s2_t1_r) + 40'(s2_t2_r);
      end
      s3_x_r    <= s2_x_r;
      s3_lo_r   <= s2_lo_r;
      s3_hi_r   <= s2_hi_r;
      s3_vmax_r <= s2_vmax_r;
      s3_last_r <= s2_last_r;
    end
  end

  // ---------------- stage 4: constriction scaling when mode is set, else the sum passes through
  logic signed [56:0] chi_prod;

  assign chi_prod = $signed({1'b0, chi_r}) * s3_acc_r + 57'sd2048;

  logic signed [44:0] s4_nv_r;
  logic signed [31:0] s4_x_r, s4_lo_r, s4_hi_r, s4_vmax_r;
  logic               s4_last_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_nv_r   <= mode_r ? chi_prod[56:12] : 45'(s3_acc_r);
      s4_x_r    <= s3_x_r;
      s4_lo_r   <= s3_lo_r;
      s4_hi_r   <= s3_hi_r;
      s4_vmax_r <= s3_vmax_r;
      s4_last_r <= s3_last_r;
    end
  end

  // ---------------- stage 5: clamp and saturate velocity
  logic signed [44:0] vmax_w, vmin_w, nv_hi, nv_cl;
  logic signed [31:0] nv_sat;

  assign vmax_w = 45'(s4_vmax_r);
  assign vmin_w = -vmax_w;

  always_comb begin
    nv_hi = (s4_nv_r > vmax_w) ? vmax_w : s4_nv_r;
    nv_cl = (nv_hi < vmin_w) ? vmin_w : nv_hi;
    if (nv_cl > 45'sd2147483647) begin
      nv_sat = 32'sh7FFF_FFFF;
    end else if (nv_cl < -45'sd2147483648) begin
      nv_sat = 32'sh8000_0000;
    end else begin
      nv_sat = nv_cl[31:0];
    end
  end

  logic signed [31:0] s5_nv_r, s5_x_r, s5_lo_r, s5_hi_r;
  logic               s5_last_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_nv_r   <= nv_sat;
      s5_x_r    <= s4_x_r;
      s5_lo_r   <= s4_lo_r;
      s5_hi_r   <= s4_hi_r;
      s5_last_r <= s4_last_r;
    end
  end

  // ---------------- stage 6: advance position, reflect off lower bound
  logic signed [35:0] nx0, lo_w;
  logic signed [33:0] nv0_neg;

  assign nx0     = 36'(s5_x_r) + 36'(s5_nv_r);
  assign lo_w    = 36'(s5_lo_r);
  assign nv0_neg = -34'(s5_nv_r) + 34'sd1;

  logic signed [35:0] s6_nx_r;
  logic signed [32:0] s6_nv_r;
  logic signed [31:0] s6_hi_r;
  logic               s6_last_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (nx0 < lo_w) begin
        s6_nx_r <= (lo_w <<< 1) - nx0;
        s6_nv_r <= nv0_neg[33:1];
      end else begin
        s6_nx_r <= nx0;
        s6_nv_r <= 33'(s5_nv_r);
      end
      s6_hi_r   <= s5_hi_r;
      s6_last_r <= s5_last_r;
    end
  end

  // ---------------- stage 7: reflect off upper bound, saturate, output register
  logic signed [35:0] hi_w, nx1;
  logic signed [33:0] nv1_neg;
  logic signed [32:0] nv1;
  logic signed [31:0] nx_sat;

  assign hi_w    = 36'(s6_hi_r);
  assign nv1_neg = -34'(s6_nv_r) + 34'sd1;

  always_comb begin
    if (s6_nx_r > hi_w) begin
      nx1 = (hi_w <<< 1) - s6_nx_r;
      nv1 = nv1_neg[33:1];
    end else begin
      nx1 = s6_nx_r;
      nv1 = s6_nv_r;
    end
    if (nx1 > 36'sd2147483647) begin
      nx_sat = 32'sh7FFF_FFFF;
    end else if (nx1 < -36'sd2147483648) begin
      nx_sat = 32'sh8000_0000;
    end else begin
      nx_sat = nx1[31:0];
    end
  end

  logic [OutDataW-1:0] out_data_r;
  logic                out_last_r;

  // the velocity is back in 32-bit range after any reflection
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {nv1[31:0], nx_sat};
      out_last_r <= s6_last_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

endmodule

// File: tb/sv/pso_particle_dimension_update_tb.sv
// Self-checking testbench for the particle swarm dimension update pipeline.
module pso_particle_dimension_update_tb;
  import pso_pdu_pkg::*;

  localparam int WFRAC = 12;
  localparam int ONE   = 1 << 16;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int NUM_DIRECTED = 19;
  localparam logic signed [ValW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] Q_MIN = 32'sh8000_0000;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [ValW-1:0] pos;
    logic signed [ValW-1:0] vel;
    logic signed [ValW-1:0] pbest;
    logic signed [ValW-1:0] nbest;
    logic signed [ValW-1:0] lo;
    logic signed [ValW-1:0] hi;
    logic [RndW-1:0]        r_cog;
    logic [RndW-1:0]        r_soc;
    logic                   last;
  } dim_in_t;

  typedef struct packed {
    logic signed [ValW-1:0] pos;
    logic signed [ValW-1:0] vel;
    logic                   last;
  } dim_out_t;

  typedef struct packed {
    logic            mode;
    logic [WgtW-1:0] inertia;
    logic [WgtW-1:0] cog;
    logic [WgtW-1:0] soc;
    logic [WgtW-1:0] chi;
    logic [LimW-1:0] vlimit;
  } swarm_cfg_t;

  typedef struct packed {
    dim_in_t                d;
    logic                   typed;
    logic signed [ValW-1:0] want_pos;
    logic signed [ValW-1:0] want_vel;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;

  swarm_cfg_t cur_cfg = '{1'b0, RST_INERTIA, RST_COG, RST_SOC, RST_CHI, '0};
  dim_out_t   pending_dims [$];
  int         mismatch_count = 0;
  int         tx_gap_pct = 0;
  int         rx_stall_pct = 0;

  // pos, vel, pbest, nbest, lo, hi, r_cog, r_soc, last | typed, position, velocity
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 1'b0}, 1'b1, 0, 0},
    '{'{Q_MAX, 0, Q_MAX, Q_MAX, Q_MIN, Q_MAX, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, Q_MAX, 0},
    '{'{Q_MIN, 0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b1, Q_MIN, 0},
    '{'{ONE, 0, ONE, ONE, 0, 2 * ONE, 16'h1234, 16'h4321, 1'b1}, 1'b1, ONE, 0},
    '{'{-ONE, 0, -ONE, -ONE, -ONE, ONE, 16'h00FF, 16'hFF00, 1'b0}, 1'b1, -ONE, 0},
    '{'{5 * ONE, ONE, 7 * ONE, 7 * ONE, 5 * ONE, 5 * ONE, 16'h8000, 16'h8000, 1'b1},
      1'b1, 5 * ONE, 0},
    '{'{0, Q_MAX, 0, 0, Q_MIN, Q_MAX, 16'h0000, 16'h0000, 1'b0}, 1'b0, 0, 0},
    '{'{0, Q_MIN, 0, 0, Q_MIN, Q_MAX, 16'h0000, 16'h0000, 1'b1}, 1'b0, 0, 0},
    // reflect off the lower bound, then off the upper bound
    '{'{0, -10 * ONE, 0, 0, -ONE, 100 * ONE, 16'h0000, 16'h0000, 1'b0}, 1'b0, 0, 0},
    '{'{0, 10 * ONE, 0, 0, -100 * ONE, ONE, 16'h0000, 16'h0000, 1'b1}, 1'b0, 0, 0},
    '{'{-10 * ONE, 0, -10 * ONE, -10 * ONE, 0, ONE, 16'h0000, 16'h0000, 1'b0}, 1'b0, 0, 0},
    // upper bound below lower bound: negative limit, reflection off the upper bound
    '{'{0, 3 * ONE, 0, 0, 5 * ONE, -5 * ONE, 16'h0000, 16'h0000, 1'b1}, 1'b0, 0, 0},
    '{'{0, 0, 0, 0, Q_MAX, Q_MIN, 16'h0000, 16'h0000, 1'b0}, 1'b0, 0, 0},
    '{'{0, 0, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, 0, 0},
    '{'{Q_MIN, 0, Q_MAX, Q_MAX, Q_MIN, Q_MAX, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, 0, 0},
    '{'{Q_MAX, 0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, 0, 0},
    '{'{0, ONE, 1, -1, -ONE, ONE, 16'h8000, 16'h8000, 1'b0}, 1'b0, 0, 0},
    '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
        32'h5555_5555, 16'hAAAA, 16'h5555, 1'b1}, 1'b0, 0, 0},
    '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
        32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 1'b0}, 1'b0, 0, 0}
  };

  pso_particle_dimension_update i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint round_q(longint a, int unsigned n);
    return (a + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip32(longint a);
    if (a > S32_HI) return S32_HI;
    if (a < S32_LO) return S32_LO;
    return a;
  endfunction

  // coefficient c*r rounded to Q4.12, then applied to the 33-bit difference
  function automatic longint pull_term(logic [WgtW-1:0] c, logic [RndW-1:0] r, longint diff);
    longint k;
    k = (longint'(c) * longint'(r) + 32768) >>> RndW;
    return round_q(k * diff, WFRAC);
  endfunction

  function automatic dim_out_t predict_update(dim_in_t d);
    longint x, v, p, g, lo, hi, t1, t2, nv, vmax, nx;
    dim_out_t r;
    x  = longint'(signed'(d.pos));
    v  = longint'(signed'(d.vel));
    p  = longint'(signed'(d.pbest));
    g  = longint'(signed'(d.nbest));
    lo = longint'(signed'(d.lo));
    hi = longint'(signed'(d.hi));
    t1 = pull_term(cur_cfg.cog, d.r_cog, p - x);
    t2 = pull_term(cur_cfg.soc, d.r_soc, g - x);
    if (cur_cfg.mode) begin
      nv = round_q(longint'(cur_cfg.chi) * (v + t1 + t2), WFRAC);
    end else begin
      nv = round_q(longint'(cur_cfg.inertia) * v, WFRAC) + t1 + t2;
    end
    if (cur_cfg.vlimit != 0) begin
      vmax = longint'(cur_cfg.vlimit);
    end else begin
      vmax = (hi - lo) >>> 1;
    end
    // clamp in this order even when the limit is negative
    if (nv > vmax) nv = vmax;
    if (nv < -vmax) nv = -vmax;
    nv = clip32(nv);
    nx = x + nv;
    if (nx < lo) begin
      nx = 2 * lo - nx;
      nv = round_q(-nv, 1);
    end
    if (nx > hi) begin
      nx = 2 * hi - nx;
      nv = round_q(-nv, 1);
    end
    r.pos  = 32'(clip32(nx));
    r.vel  = 32'(clip32(nv));
    r.last = d.last;
    return r;
  endfunction

  function automatic dim_in_t random_dim();
    dim_in_t d;
    longint mag, lo, hi, span, x, tmp;
    int unsigned shape;
    shape   = $urandom_range(9, 0);
    d.r_cog = RndW'($urandom);
    d.r_soc = RndW'($urandom);
    if ($urandom_range(7, 0) == 0) d.r_cog = $urandom_range(1, 0) ? '1 : '0;
    if ($urandom_range(7, 0) == 0) d.r_soc = $urandom_range(1, 0) ? '1 : '0;
    d.last = 1'($urandom_range(1, 0));
    if (shape == 6 || shape == 7) begin
      d.pos   = $urandom;
      d.vel   = $urandom;
      d.pbest = $urandom;
      d.nbest = $urandom;
      d.lo    = $urandom;
      d.hi    = $urandom;
      return d;
    end
    // ordered bounds at a random scale, coordinates inside; shapes 8, 9 break this
    mag  = longint'(1) << $urandom_range(30, 8);
    lo   = longint'($urandom_range(32'(2 * mag - 1), 0)) - mag;
    hi   = lo + 1 + longint'($urandom_range(32'(mag - 1), 0));
    span = hi - lo;
    x    = lo + longint'($urandom_range(32'(span), 0));
    if ($urandom_range(7, 0) == 0) x = $urandom_range(1, 0) ? hi : lo;
    d.pos   = 32'(x);
    d.pbest = 32'(lo + longint'($urandom_range(32'(span), 0)));
    d.nbest = 32'(lo + longint'($urandom_range(32'(span), 0)));
    d.vel   = 32'(longint'($urandom_range(32'(2 * span), 0)) - span);
    if (shape == 8) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    d.lo = 32'(lo);
    d.hi = 32'(hi);
    if (shape == 9) d.pos = $urandom;
    return d;
  endfunction

  task automatic flag_mismatch(input string what, input logic [ValW-1:0] got,
                               input logic [ValW-1:0] want);
    mismatch_count++;
    $display("[%0t] %s mismatch: got %h, want %h", $time, what, got, want);
  endtask

  task automatic send_dim(input dim_in_t d);
    if ($urandom_range(99, 0) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < tx_gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d.r_soc, d.r_cog, d.hi, d.lo, d.nbest, d.pbest, d.vel, d.pos};
    in_tlast  <= d.last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    while (pending_dims.size() != 0) @(posedge clk);
  endtask

  // write every register, then drop the enable
  task automatic load_settings(input swarm_cfg_t c);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_MODE;
    cfg_wdata <= CfgDataW'(c.mode);
    @(posedge clk);
    cfg_addr  <= REG_INERTIA;
    cfg_wdata <= CfgDataW'(c.inertia);
    @(posedge clk);
    cfg_addr  <= REG_COG;
    cfg_wdata <= CfgDataW'(c.cog);
    @(posedge clk);
    cfg_addr  <= REG_SOC;
    cfg_wdata <= CfgDataW'(c.soc);
    @(posedge clk);
    cfg_addr  <= REG_CHI;
    cfg_wdata <= CfgDataW'(c.chi);
    @(posedge clk);
    cfg_addr  <= REG_VLIMIT;
    cfg_wdata <= CfgDataW'(c.vlimit);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_cfg = c;
  endtask

  always @(posedge clk) begin : result_check
    dim_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_dims.size() == 0) begin
        flag_mismatch("unexpected result", out_tdata[ValW-1:0], '0);
      end else begin
        want = pending_dims.pop_front();
        if (out_tdata[ValW-1:0] !== want.pos)
          flag_mismatch("new_position", out_tdata[ValW-1:0], want.pos);
        if (out_tdata[2*ValW-1:ValW] !== want.vel)
          flag_mismatch("new_velocity", out_tdata[2*ValW-1:ValW], want.vel);
        if (out_tlast !== want.last)
          flag_mismatch("last_dimension_out", ValW'(out_tlast), ValW'(want.last));
      end
    end
    out_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    swarm_cfg_t phase_cfg [NUM_PHASES];
    int         phase_gap [NUM_PHASES];
    int         phase_stall [NUM_PHASES];
    dim_in_t    d;
    dir_row_t   row;

    phase_cfg[0] = '{1'b0, RST_INERTIA, RST_COG, RST_SOC, RST_CHI, '0};
    phase_cfg[1] = '{1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF};
    phase_cfg[2] = '{1'b1, 16'hFFFF, 16'd8397, 16'd8397, 16'd2983, '0};
    phase_cfg[3] = '{1'b0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 31'd1};
    phase_cfg[4] = '{1'b0, WgtW'($urandom), WgtW'($urandom), WgtW'($urandom),
                     WgtW'($urandom), LimW'($urandom) >> $urandom_range(30, 0)};
    phase_cfg[5] = '{1'b1, WgtW'($urandom), WgtW'($urandom), WgtW'($urandom),
                     WgtW'($urandom), $urandom_range(1, 0) ? LimW'($urandom) : '0};
    phase_gap   = '{20, 20, 80, 80, 0, 0};
    phase_stall = '{80, 80, 20, 20, 0, 0};

    rst_n      <= 1'b0;
    cfg_wr_en  <= 1'b0;
    cfg_addr   <= REG_MODE;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows run on the register values left by reset
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_rows[i];
      send_dim(row.d);
      if (row.typed) begin
        pending_dims.push_back(dim_out_t'{row.want_pos, row.want_vel, row.d.last});
      end else begin
        pending_dims.push_back(predict_update(row.d));
      end
    end
    in_tvalid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      load_settings(phase_cfg[ph]);
      tx_gap_pct   = phase_gap[ph];
      rx_stall_pct = phase_stall[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        d = random_dim();
        send_dim(d);
        pending_dims.push_back(predict_update(d));
        // hold the sender until the pipe has emptied once
        if (ph == 2 && n == ITEMS_PER_PHASE / 2) begin
          in_tvalid <= 1'b0;
          wait_drained();
        end
      end
      in_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
